// File: sv/tfn_pkg.sv
// Shared widths and beat types for the triangle face normal block.
package tfn_pkg;

  localparam int CW  = 16;          // corner coordinate width
  localparam int NW  = 16;          // normal component width
  localparam int FB  = NW - 2;      // fraction bits of the normal
  localparam int QW  = FB + 1;      // magnitude bits of the normal
  localparam int EW  = CW + 1;      // edge vector width
  localparam int PW  = 2 * EW;      // signed edge product width
  localparam int XW  = PW + 1;      // signed cross component width
  localparam int MW  = XW - 1;      // cross component magnitude width
  localparam int SQW = 2 * MW;      // squared magnitude width
  localparam int SW  = SQW + 2;     // sum of three squares width
  localparam int W   = SW + 2 * FB + 3;  // working width of the root cells

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
  } corners_t;

  typedef struct packed {
    logic signed [NW-1:0] norm_x;
    logic signed [NW-1:0] norm_y;
    logic signed [NW-1:0] norm_z;
    logic                 degenerate;
  } normal_t;

  // Data handed from one root cell to the next.
  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [2:0]           neg;
    logic [W-1:0]         t;
    logic [2:0][W-1:0]    p;
    logic [2:0][W-1:0]    d;
    logic [2:0][QW-1:0]   q;
  } cell_t;

endpackage

// File: sv/tfn_front.sv
// Front pipeline: edges, cross product, squares and root cell seed.
module tfn_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid,
  input  tfn_pkg::corners_t   corners,
  output tfn_pkg::cell_t      seed
);

  logic [4:0] vld;
  logic signed [tfn_pkg::EW-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [tfn_pkg::PW-1:0] pr [6];
  logic [2:0][tfn_pkg::MW-1:0]   mg;
  logic [2:0]                    ng, ng2;
  logic [2:0][tfn_pkg::SQW-1:0]  sq;
  logic signed [tfn_pkg::XW-1:0] n [3];
  logic [tfn_pkg::SW-1:0]        s_sum;
  tfn_pkg::cell_t                sd;

  always_comb begin
    n[0] = tfn_pkg::XW'(pr[0]) - tfn_pkg::XW'(pr[1]);
    n[1] = tfn_pkg::XW'(pr[2]) - tfn_pkg::XW'(pr[3]);
    n[2] = tfn_pkg::XW'(pr[4]) - tfn_pkg::XW'(pr[5]);
    s_sum = tfn_pkg::SW'(sq[0]) + tfn_pkg::SW'(sq[1]) + tfn_pkg::SW'(sq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], valid};
    end
    if (en) begin
      ux <= {corners.b_x[tfn_pkg::CW-1], corners.b_x} - {corners.a_x[tfn_pkg::CW-1], corners.a_x};
      uy <= {corners.b_y[tfn_pkg::CW-1], corners.b_y} - {corners.a_y[tfn_pkg::CW-1], corners.a_y};
      uz <= {corners.b_z[tfn_pkg::CW-1], corners.b_z} - {corners.a_z[tfn_pkg::CW-1], corners.a_z};
      vx <= {corners.c_x[tfn_pkg::CW-1], corners.c_x} - {corners.a_x[tfn_pkg::CW-1], corners.a_x};
      vy <= {corners.c_y[tfn_pkg::CW-1], corners.c_y} - {corners.a_y[tfn_pkg::CW-1], corners.a_y};
      vz <= {corners.c_z[tfn_pkg::CW-1], corners.c_z} - {corners.a_z[tfn_pkg::CW-1], corners.a_z};
      pr[0] <= uy * vz;
      pr[1] <= vy * uz;
      pr[2] <= uz * vx;
      pr[3] <= vz * ux;
      pr[4] <= ux * vy;
      pr[5] <= vx * uy;
      for (int i = 0; i < 3; i++) begin
        ng[i] <= n[i][tfn_pkg::XW-1];
        mg[i] <= n[i][tfn_pkg::XW-1] ? tfn_pkg::MW'(-n[i]) : tfn_pkg::MW'(n[i]);
        sq[i] <= tfn_pkg::SQW'(mg[i]) * tfn_pkg::SQW'(mg[i]);
      end
      ng2 <= ng;
      sd.valid <= vld[3];
      sd.zero  <= (s_sum == '0);
      sd.neg   <= ng2;
      sd.t     <= tfn_pkg::W'(s_sum) << (2 * tfn_pkg::FB);
      for (int i = 0; i < 3; i++) begin
        sd.p[i] <= '0;
        sd.d[i] <= tfn_pkg::W'(sq[i]) << (2 * tfn_pkg::FB);
        sd.q[i] <= '0;
      end
    end
  end

  always_comb begin
    seed       = sd;
    seed.valid = vld[4];
  end

endmodule

// File: sv/tfn_cell.sv
// One root cell: settles one bit of each normal magnitude.
module tfn_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  tfn_pkg::cell_t din,
  output tfn_pkg::cell_t dout
);

  tfn_pkg::cell_t nx;
  logic [tfn_pkg::W-1:0] delta;
  logic take;

  // With t = S*4^b and p = S*Y*2^(b+1), setting bit b grows q^2*S by p + t.
  always_comb begin
    nx = din;
    delta = '0;
    take = 1'b0;
    for (int i = 0; i < 3; i++) begin
      delta = din.p[i] + din.t;
      take  = (delta <= din.d[i]);
      nx.d[i] = take ? din.d[i] - delta : din.d[i];
      nx.p[i] = (take ? din.p[i] + (din.t << 1) : din.p[i]) >> 1;
      nx.q[i] = {din.q[i][tfn_pkg::QW-2:0], take};
    end
    nx.t = din.t >> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= nx.valid;
    end
    if (en) begin
      dout.zero <= nx.zero;
      dout.neg  <= nx.neg;
      dout.t    <= nx.t;
      dout.p    <= nx.p;
      dout.d    <= nx.d;
      dout.q    <= nx.q;
    end
  end

endmodule

// File: sv/triangle_face_normal.sv
// Top level of the triangle face normal block.
// Usage:
//   A beat on the corner channel carries the three corners of one triangle
//   in signed Q8.8. The block forms the edges, their cross product and
//   returns the negated unit normal in signed Q1.14 on the normal channel,
//   each component rounded toward zero. A triangle whose cross product is
//   zero yields a zero normal with degenerate set.
// Pipeline and throughput:
//   One triangle is taken every cycle while corner_stall is low. Each result
//   passes through five front stages (edges, products, cross terms,
//   squares, sum), fifteen root cells that settle one magnitude bit each,
//   and the output register.
// Stall:
//   The whole pipeline moves as one. While a finished result waits in the
//   output register under stall, every stage holds and corner_stall is high;
//   an empty output register never blocks the pipeline.
// Reset:
//   rst clears all valid bits; no result is in flight afterwards.
module triangle_face_normal (
  input  logic              clk,
  input  logic              rst,
  input  logic              corner_valid,
  output logic              corner_stall,
  input  tfn_pkg::corners_t corners,
  output logic              norm_valid,
  input  logic              norm_stall,
  output tfn_pkg::normal_t  normal
);

  logic en;
  tfn_pkg::cell_t chain [tfn_pkg::QW+1];
  logic [2:0][tfn_pkg::NW-1:0] comp;
  tfn_pkg::cell_t last;

  // The pipeline advances unless a held result is being stalled.
  assign en           = !(norm_valid && norm_stall);
  assign corner_stall = !en;

  tfn_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid   (corner_valid),
    .corners (corners),
    .seed    (chain[0])
  );

  // The row of cells, most significant magnitude bit first.
  for (genvar k = 0; k < tfn_pkg::QW; k++) begin : g_cell
    tfn_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  assign last = chain[tfn_pkg::QW];

  // The output is the negated normal, so a negative cross term gives a
  // positive component.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (last.zero) begin
        comp[i] = '0;
      end else if (last.neg[i]) begin
        comp[i] = tfn_pkg::NW'(last.q[i]);
      end else begin
        comp[i] = -tfn_pkg::NW'(last.q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_valid <= 1'b0;
    end else if (en) begin
      norm_valid <= last.valid;
    end
    if (en) begin
      normal.norm_x     <= comp[0];
      normal.norm_y     <= comp[1];
      normal.norm_z     <= comp[2];
      normal.degenerate <= last.zero;
    end
  end

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    norm_valid && normal.degenerate |->
      normal.norm_x == '0 && normal.norm_y == '0 && normal.norm_z == '0)
    else $error("degenerate result with nonzero normal");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !norm_valid)
    else $error("result valid right after reset");

  a_range_x: assert property (@(posedge clk) disable iff (rst)
    norm_valid |-> normal.norm_x <= 16'sd16384 && normal.norm_x >= -16'sd16384)
    else $error("normal x out of unit range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    corner_stall |=> $stable(chain[tfn_pkg::QW]))
    else $error("cell row moved while stalled");
`endif

endmodule
